FILE: src/lswc_pkg.sv
//------------------------------------------------------------------------------
// lswc_pkg
// Types shared by the line segment window clipper.
//------------------------------------------------------------------------------
`default_nettype none
package lswc_pkg;

   localparam int unsigned COORD_W = 12;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIN_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_RIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_BOTTOM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_TOP    = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                      visible;
      logic signed [COORD_W-1:0] clip_start_x;
      logic signed [COORD_W-1:0] clip_start_y;
      logic signed [COORD_W-1:0] clip_end_x;
      logic signed [COORD_W-1:0] clip_end_y;
   } rsp_type;

endpackage
`default_nettype wire

FILE: src/lswc_cell.sv
//------------------------------------------------------------------------------
// lswc_cell
// Generic pipeline cell: one register stage with stall-held contents.
//------------------------------------------------------------------------------
`default_nettype none
module lswc_cell #(
   parameter int unsigned WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   output logic [WIDTH-1:0]      out_data
);
   logic             valid_ff;
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

FILE: src/line_segment_window_clipper.sv
//------------------------------------------------------------------------------
// line_segment_window_clipper
// Liang-Barsky clipper of segments against a programmable window.
//------------------------------------------------------------------------------
// Usage: a segment request enters on req_ (valid/stall), the clipped result
// leaves on rsp_ (valid/stall). The csr_ port writes the four window edges
// (index 0 left, 1 right, 2 bottom, 3 top); write only while idle.
// The datapath is a chain of register cells:
//   stage 1: deltas and edge terms p, q
//   stage 2..5: one window edge per stage updates t1 or t2 (cross multiply) or rejects
//   stage 6: visibility test and numerators of the four clipped coords
//   stage 7..: restoring divider, one quotient bit per stage
//   last stage: output register
// Throughput: one segment per clock while rsp_ is not stalled.
// The whole chain advances together; a stall on rsp_ with a valid result
// waiting freezes every stage and asserts req_stall.
// Reset empties the chain and restores the reset window.
//------------------------------------------------------------------------------
`default_nettype none
module line_segment_window_clipper (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire lswc_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output lswc_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lswc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lswc_pkg::COORD_W-1:0]        csr_wdata
);
   localparam int unsigned CW = lswc_pkg::COORD_W;
   localparam int unsigned DW = CW + 1;   // delta, q
   localparam int unsigned PW = 2*DW + 1; // numerators of lerp
   localparam int unsigned NDIV = PW;     // quotient magnitude bits

   logic signed [CW-1:0] win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_right_ff  <= CW'(2047);
         win_bottom_ff <= '0;
         win_top_ff    <= CW'(2047);
      end else if (csr_valid) begin
         case (csr_index)
            lswc_pkg::CSR_WIN_LEFT:   win_left_ff   <= csr_wdata;
            lswc_pkg::CSR_WIN_RIGHT:  win_right_ff  <= csr_wdata;
            lswc_pkg::CSR_WIN_BOTTOM: win_bottom_ff <= csr_wdata;
            lswc_pkg::CSR_WIN_TOP:    win_top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-stage record
   typedef struct packed {
      logic signed [CW-1:0]   x1;
      logic signed [CW-1:0]   y1;
      logic signed [DW-1:0]   dx;
      logic signed [DW-1:0]   dy;
      logic signed [4*DW-1:0] pq_p;
      logic signed [4*DW-1:0] pq_q;
      logic                   rej;
      logic signed [DW-1:0]   n1;
      logic        [DW-1:0]   d1;
      logic signed [DW-1:0]   n2;
      logic        [DW-1:0]   d2;
   } edge_type;

   typedef struct packed {
      logic              vis;
      logic [3:0]        neg;
      logic [4*PW-1:0]   rem;   // running remainders (magnitude)
      logic [4*PW-1:0]   quo;   // quotient bits shifted in
      logic [DW-1:0]     d1;
      logic [DW-1:0]     d2;
   } div_type;

   localparam int unsigned EW = $bits(edge_type);
   localparam int unsigned VW = $bits(div_type);

   logic advance;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 1
   edge_type s0;
   always_comb begin
      logic signed [DW-1:0] x1, y1, x2, y2;
      x1 = DW'(req_data.start_x);
      y1 = DW'(req_data.start_y);
      x2 = DW'(req_data.end_x);
      y2 = DW'(req_data.end_y);
      s0 = '0;
      s0.x1 = req_data.start_x;
      s0.y1 = req_data.start_y;
      s0.dx = x2 - x1;
      s0.dy = y2 - y1;
      s0.pq_p[0*DW +: DW] = x1 - x2;
      s0.pq_p[1*DW +: DW] = x2 - x1;
      s0.pq_p[2*DW +: DW] = y1 - y2;
      s0.pq_p[3*DW +: DW] = y2 - y1;
      s0.pq_q[0*DW +: DW] = x1 - DW'(win_left_ff);
      s0.pq_q[1*DW +: DW] = DW'(win_right_ff) - x1;
      s0.pq_q[2*DW +: DW] = y1 - DW'(win_bottom_ff);
      s0.pq_q[3*DW +: DW] = DW'(win_top_ff) - y1;
      s0.rej = 1'b0;
      s0.n1 = '0;
      s0.d1 = DW'(1);
      s0.n2 = DW'(1);
      s0.d2 = DW'(1);
   end

   logic           ev [0:4];
   logic [EW-1:0]  ed [0:4];

   lswc_cell #(.WIDTH(EW)) u_in (
      .clock, .reset, .advance,
      .in_valid(req_valid), .in_data(s0),
      .out_valid(ev[0]), .out_data(ed[0])
   );

   for (genvar e = 0; e < 4; e++) begin : g_edge
      edge_type c, n;
      always_comb begin
         logic signed [DW-1:0]   p, q;
         logic signed [2*DW:0]   lhs, rhs;
         c = edge_type'(ed[e]);
         n = c;
         lhs = '0;
         rhs = '0;
         p = c.pq_p[e*DW +: DW];
         q = c.pq_q[e*DW +: DW];
         if (p == '0) begin
            if (q < 0) n.rej = 1'b1;
         end else if (p < 0) begin
            lhs = (2*DW+1)'(-q) * $signed({1'b0, c.d1});
            rhs = (2*DW+1)'(c.n1) * (2*DW+1)'(-p);
            if (lhs > rhs) begin
               n.n1 = -q;
               n.d1 = -p;
            end
         end else begin
            lhs = (2*DW+1)'(q) * $signed({1'b0, c.d2});
            rhs = (2*DW+1)'(c.n2) * (2*DW+1)'(p);
            if (lhs < rhs) begin
               n.n2 = q;
               n.d2 = p;
            end
         end
      end
      lswc_cell #(.WIDTH(EW)) u_edge (
         .clock, .reset, .advance,
         .in_valid(ev[e]), .in_data(n),
         .out_valid(ev[e+1]), .out_data(ed[e+1])
      );
   end

   // stage 6: visibility and lerp numerators base*den + num*delta
   div_type v0;
   always_comb begin
      edge_type c;
      logic signed [2*DW:0] a, b;
      logic signed [PW-1:0] t [0:3];
      c = edge_type'(ed[4]);
      a = (2*DW+1)'(c.n1) * $signed({1'b0, c.d2});
      b = (2*DW+1)'(c.n2) * $signed({1'b0, c.d1});
      v0 = '0;
      v0.vis = !c.rej && (a < b);
      v0.d1 = c.d1;
      v0.d2 = c.d2;
      t[0] = PW'(c.x1) * $signed({1'b0, c.d1}) + PW'(c.n1) * PW'(c.dx);
      t[1] = PW'(c.y1) * $signed({1'b0, c.d1}) + PW'(c.n1) * PW'(c.dy);
      t[2] = PW'(c.x1) * $signed({1'b0, c.d2}) + PW'(c.n2) * PW'(c.dx);
      t[3] = PW'(c.y1) * $signed({1'b0, c.d2}) + PW'(c.n2) * PW'(c.dy);
      for (int k = 0; k < 4; k++) begin
         v0.neg[k] = t[k][PW-1];
         v0.quo[k*PW +: PW] = t[k][PW-1] ? PW'(-t[k]) : PW'(t[k]);
      end
   end

   logic          dv [0:NDIV];
   logic [VW-1:0] dd [0:NDIV];

   lswc_cell #(.WIDTH(VW)) u_lerp (
      .clock, .reset, .advance,
      .in_valid(ev[4]), .in_data(v0),
      .out_valid(dv[0]), .out_data(dd[0])
   );

   // restoring division: quo holds dividend bits shifting out, quotient in
   for (genvar s = 0; s < NDIV; s++) begin : g_div
      div_type c, n;
      always_comb begin
         logic [PW:0]   r;
         logic [PW-1:0] den;
         c = div_type'(dd[s]);
         n = c;
         for (int k = 0; k < 4; k++) begin
            den = (k < 2) ? PW'(c.d1) : PW'(c.d2);
            r = {c.rem[k*PW +: PW], c.quo[k*PW + PW-1]};
            n.quo[k*PW +: PW] = {c.quo[k*PW +: PW-1], 1'b0};
            if (r >= {1'b0, den}) begin
               r = r - {1'b0, den};
               n.quo[k*PW] = 1'b1;
            end
            n.rem[k*PW +: PW] = r[PW-1:0];
         end
      end
      lswc_cell #(.WIDTH(VW)) u_div (
         .clock, .reset, .advance,
         .in_valid(dv[s]), .in_data(n),
         .out_valid(dv[s+1]), .out_data(dd[s+1])
      );
   end

   lswc_pkg::rsp_type r0;
   always_comb begin
      div_type c;
      logic [PW-1:0] qv [0:3];
      c = div_type'(dd[NDIV]);
      for (int k = 0; k < 4; k++) begin
         qv[k] = c.neg[k] ? PW'(-c.quo[k*PW +: PW]) : c.quo[k*PW +: PW];
      end
      r0.visible      = c.vis;
      r0.clip_start_x = c.vis ? CW'(qv[0]) : '0;
      r0.clip_start_y = c.vis ? CW'(qv[1]) : '0;
      r0.clip_end_x   = c.vis ? CW'(qv[2]) : '0;
      r0.clip_end_y   = c.vis ? CW'(qv[3]) : '0;
   end

   logic [$bits(lswc_pkg::rsp_type)-1:0] rsp_bits;
   lswc_cell #(.WIDTH($bits(lswc_pkg::rsp_type))) u_out (
      .clock, .reset, .advance,
      .in_valid(dv[NDIV]), .in_data(r0),
      .out_valid(rsp_valid), .out_data(rsp_bits)
   );
   assign rsp_data = lswc_pkg::rsp_type'(rsp_bits);
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line segment window clipper: segment requests
// under several windows, each result compared with an exact rational clipper.
//------------------------------------------------------------------------------
module tb_top;
   localparam int unsigned CW = lswc_pkg::COORD_W;
   localparam int unsigned RQW = $bits(lswc_pkg::req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lswc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lswc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lswc_pkg::CSR_IDX_W-1:0] csr_index = lswc_pkg::CSR_WIN_LEFT;
   logic [CW-1:0] csr_wdata = '0;

   lswc_pkg::rsp_type clipped_q[$];
   logic signed [CW-1:0] win_l, win_r, win_b, win_t;
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   line_segment_window_clipper DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      #50ms;
      $display("line_segment_window_clipper: mismatch");
      $finish;
   end

   // fractions kept as num/den with den > 0, compared by cross multiplication
   function automatic lswc_pkg::rsp_type clip_segment(lswc_pkg::req_type s);
      longint x1, y1, dx, dy, n1, d1, n2, d2, rn, rd;
      longint p[4];
      longint q[4];
      bit rejected;
      lswc_pkg::rsp_type r;
      x1 = s.start_x;
      y1 = s.start_y;
      dx = longint'(s.end_x) - x1;
      dy = longint'(s.end_y) - y1;
      n1 = 0; d1 = 1; n2 = 1; d2 = 1;
      rejected = 1'b0;
      r = '0;
      p[0] = -dx; q[0] = x1 - longint'(win_l);
      p[1] = dx;  q[1] = longint'(win_r) - x1;
      p[2] = -dy; q[2] = y1 - longint'(win_b);
      p[3] = dy;  q[3] = longint'(win_t) - y1;
      for (int i = 0; i < 4; i++) begin
         if (p[i] == 0) begin
            if (q[i] < 0) rejected = 1'b1;
         end else if (p[i] < 0) begin
            rn = -q[i]; rd = -p[i];
            if (rn * d1 > n1 * rd) begin
               n1 = rn; d1 = rd;
            end
         end else begin
            rn = q[i]; rd = p[i];
            if (rn * d2 < n2 * rd) begin
               n2 = rn; d2 = rd;
            end
         end
      end
      if (!rejected && n1 * d2 < n2 * d1) begin
         r.visible      = 1'b1;
         r.clip_start_x = CW'((x1 * d1 + n1 * dx) / d1);
         r.clip_start_y = CW'((y1 * d1 + n1 * dy) / d1);
         r.clip_end_x   = CW'((x1 * d2 + n2 * dx) / d2);
         r.clip_end_y   = CW'((y1 * d2 + n2 * dy) / d2);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      lswc_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (clipped_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %p", $time, rsp_data);
         end else begin
            exp_r = clipped_q.pop_front();
            if (rsp_data.visible !== exp_r.visible
                || rsp_data.clip_start_x !== exp_r.clip_start_x
                || rsp_data.clip_start_y !== exp_r.clip_start_y
                || rsp_data.clip_end_x !== exp_r.clip_end_x
                || rsp_data.clip_end_y !== exp_r.clip_end_y) begin
               errors++;
               $display("%0t: expected %p actual %p", $time, exp_r, rsp_data);
            end
         end
      end
   end

   task automatic send_segment(input lswc_pkg::req_type s);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      clipped_q.push_back(clip_segment(s));
   endtask

   task automatic send_points(input int ax, input int ay, input int bx, input int by);
      lswc_pkg::req_type s;
      s.start_x = CW'(ax); s.start_y = CW'(ay); s.end_x = CW'(bx); s.end_y = CW'(by);
      send_segment(s);
   endtask

   // let the pipeline empty before any window change
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (clipped_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_edge(input logic [lswc_pkg::CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CW'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         lswc_pkg::CSR_WIN_LEFT:   win_l = CW'(val);
         lswc_pkg::CSR_WIN_RIGHT:  win_r = CW'(val);
         lswc_pkg::CSR_WIN_BOTTOM: win_b = CW'(val);
         default:                  win_t = CW'(val);
      endcase
   endtask

   task automatic set_window(input int l, input int r, input int b, input int t);
      drain();
      write_edge(lswc_pkg::CSR_WIN_LEFT, l);
      write_edge(lswc_pkg::CSR_WIN_RIGHT, r);
      write_edge(lswc_pkg::CSR_WIN_BOTTOM, b);
      write_edge(lswc_pkg::CSR_WIN_TOP, t);
      csr_valid <= 1'b0;
   endtask

   function automatic int near_coord(input int lo, input int hi);
      int a, b, v;
      a = (lo < hi ? lo : hi) - 64;
      b = (lo < hi ? hi : lo) + 64;
      v = a + $urandom_range(b - a);
      if (v < -2048) v = -2048;
      if (v > 2047) v = 2047;
      return v;
   endfunction

   task automatic test_directed;
      send_points(-2048, -2048, 2047, 2047);
      send_points(2047, -2048, -2048, 2047);
      send_points(100, 100, 100, 100);        // degenerate, inside
      send_points(-5, 100, -5, 100);          // degenerate, outside the reset window
      send_points(0, 0, 0, 0);                // degenerate, on the corner of the reset window
      send_points(-100, 50, 2047, 50);        // horizontal, enters the reset window from the left
      send_points(50, -100, 50, 2047);        // vertical
      send_points(-100, -50, 500, -50);       // horizontal, below the reset window
      send_points(-10, 10, 10, -10);          // touches the corner of the reset window only
      send_points(0, -10, 0, 10);             // runs along the left edge of the reset window
      send_points(-2048, 0, -1, 0);
      send_points(2047, 2047, 2047, 2047);
      send_points(1000, 1000, -2048, -1);
      send_points(-1, -1, -2048, -2048);
   endtask

   task automatic test_inverted_window;
      set_window(100, -100, -2048, 2047);
      send_points(0, 0, 0, 0);
      send_points(-2048, 0, 2047, 0);
      set_window(-2048, 2047, 500, 400);
      send_points(0, 450, 0, 450);
      send_points(0, -2048, 0, 2047);
   endtask

   task automatic test_random(input int n, input int idle_p, input int stall_p);
      lswc_pkg::req_type s;
      logic [63:0] rnd;
      int mode;
      idle_pct = idle_p;
      stall_pct = stall_p;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(9);
         rnd = {$urandom, $urandom};
         s = rnd[RQW-1:0];
         if (mode < 6) begin
            s.start_x = CW'(near_coord(win_l, win_r));
            s.start_y = CW'(near_coord(win_b, win_t));
            s.end_x   = CW'(near_coord(win_l, win_r));
            s.end_y   = CW'(near_coord(win_b, win_t));
         end
         if (mode == 6) s.end_x = s.start_x;
         if (mode == 7) s.end_y = s.start_y;
         if (mode == 8) begin
            s.end_x = s.start_x;
            s.end_y = s.start_y;
         end
         send_segment(s);
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      win_l = 0; win_r = 2047; win_b = 0; win_t = 2047;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500, 0, 0);
      set_window(-2048, 2047, -2048, 2047);
      test_directed();
      test_random(500, 75, 0);
      set_window(-300, 700, -900, 150);
      test_random(500, 0, 75);
      set_window(10, 10, 20, 20);             // single-point window
      test_random(100, 14, 14);
      set_window(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                 int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048);
      test_random(400, 14, 14);
      test_inverted_window();
      drain();
      if (errors == 0)
         $display("line_segment_window_clipper: match");
      else
         $display("line_segment_window_clipper: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
src/lswc_pkg.sv
src/lswc_cell.sv
src/line_segment_window_clipper.sv
tb/tb_top.sv
